@@ hw/rtl/mbrle_pkg.sv @@
package mbrle_pkg;

  // Configuration register widths and APB decode
  localparam int unsigned CfgW      = 9;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam logic ApbSelWidth      = 1'b0;  // paddr[2] selects the register
  localparam logic ApbSelHeight     = 1'b1;

  // Span arithmetic is carried at nine bits, enough for a full 256-pixel line
  localparam int unsigned LenW      = 9;
  localparam int unsigned ChunkW    = 7;
  localparam int unsigned NumChunks = 3;
  localparam logic [LenW-1:0] ChunkMax = LenW'(127);

  // Code bytes
  localparam logic [7:0] CodeNextLine = 8'h80;
  localparam logic [7:0] CodeEnd      = 8'h00;
  localparam logic       FlagClear    = 1'b0;
  localparam logic       FlagSet      = 1'b1;

  // Result slots held for one pixel, drained lowest first
  localparam int unsigned NumSlots  = 8;
  localparam int unsigned SlotAdv   = 0;
  localparam int unsigned SlotClr0  = 1;
  localparam int unsigned SlotSet0  = 4;
  localparam int unsigned SlotEnd   = 7;

  typedef struct packed {
    logic [NumChunks-1:0]              vld;
    logic [NumChunks-1:0][ChunkW-1:0]  len;
  } chunk_set_t;

endpackage

@@ hw/rtl/mbrle_chunker.sv @@
module mbrle_chunker (
  input  logic                       en_i,
  input  logic [mbrle_pkg::LenW-1:0] from_i,
  input  logic [mbrle_pkg::LenW-1:0] to_i,
  output mbrle_pkg::chunk_set_t      chunks_o,
  output logic [mbrle_pkg::LenW-1:0] pos_o
);
  import mbrle_pkg::*;

  logic [LenW-1:0] span;
  logic [LenW-1:0] len0, rem0, len1, len2;

  // Split the span into chunks of at most 127
  always_comb begin
    span = (en_i && (to_i > from_i)) ? (to_i - from_i) : '0;
    len0 = (span > ChunkMax) ? ChunkMax : span;
    rem0 = span - len0;
    len1 = (rem0 > ChunkMax) ? ChunkMax : rem0;
    len2 = rem0 - len1;
  end

  assign chunks_o.len[0] = len0[ChunkW-1:0];
  assign chunks_o.len[1] = len1[ChunkW-1:0];
  assign chunks_o.len[2] = len2[ChunkW-1:0];
  assign chunks_o.vld    = {(len2 != '0), (len1 != '0), (len0 != '0)};

  // Coded position moves to the target only when something was coded
  assign pos_o = (span != '0) ? to_i : from_i;

endmodule

@@ hw/rtl/mono_bitmap_run_length_encoder.sv @@
// One-bit raster run-length encoder.
// Pixel channel: one pixel_set_i beat per pixel in raster order (in_valid_i/in_ready_o).
// Code channel: one code beat per result with code_byte_o, repeat_count_o and
// last_of_run_o (out_valid_o/out_ready_i); last_of_run_o marks the final code of a pixel.
// APB port: image_width at 0x0, image_height at 0x4, nine bits each, reset to 256.
// A register write restarts the image; write only while the block is idle.
// Path: a pixel lands in the input register on acceptance, is coded from there into the
// code buffer once the buffer has room, and its codes are offered from the code buffer.
// Throughput: one pixel per cycle while pixels cause no codes; a pixel that causes
// n codes (up to six) holds the code buffer until they leave, one code per cycle while the
// receiver is ready, and a following pixel that also causes codes waits for it to drain.
// The one-entry input register and the code buffer let a new pixel be taken while
// codes still wait, so a stalled receiver only backs up pixels once both are full.
// Reset empties both stages, restores the image size and starts at the first pixel.
module mono_bitmap_run_length_encoder #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mbrle_pkg::ApbAddrW-1:0] paddr,
  input  logic [mbrle_pkg::ApbDataW-1:0] pwdata,
  output logic [mbrle_pkg::ApbDataW-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           pixel_set_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     code_byte_o,
  output logic [7:0]                     repeat_count_o,
  output logic                           last_of_run_o
);
  import mbrle_pkg::*;

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned RowW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CcW  = ColW + 1;
  localparam logic [CfgW-1:0] MaxW = CfgW'(MAX_WIDTH);
  localparam logic [CfgW-1:0] MaxH = CfgW'(MAX_HEIGHT);

  // Configuration registers
  logic [CfgW-1:0] width_q, height_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(256);
      height_q <= CfgW'(256);
    end else if (cfg_wr) begin
      if (paddr[2] == ApbSelWidth) begin
        width_q <= pwdata[CfgW-1:0];
      end else begin
        height_q <= pwdata[CfgW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == ApbSelHeight) ? ApbDataW'(height_q) : ApbDataW'(width_q);

  // Clamp sizes: zero acts as one, oversize acts as the maximum
  logic [CfgW-1:0] width_eff, height_eff;
  assign width_eff  = (width_q == '0) ? CfgW'(1) : ((width_q > MaxW) ? MaxW : width_q);
  assign height_eff = (height_q == '0) ? CfgW'(1) : ((height_q > MaxH) ? MaxH : height_q);

  // Input register
  logic in_vld_q, pix_q, fire;

  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q <= pixel_set_i;
    end
  end

  // Position state
  logic [ColW-1:0] column_q, column_d;
  logic [RowW-1:0] row_q, row_d, coded_row_q, coded_row_d;
  logic [CcW-1:0]  coded_column_q, coded_column_d;
  logic            in_set_run_q, in_set_run_d;

  logic [LenW-1:0] col9, row9, cc1, cc2, cc3, set_to;
  logic            last_col, last_row, run_start, do_adv, set_en, img_end;
  chunk_set_t      clr_chunks, set_chunks;
  logic [NumSlots-1:0] new_mask;

  always_comb begin
    col9      = LenW'(column_q);
    row9      = LenW'(row_q);
    last_col  = (col9 + LenW'(1)) >= width_eff;
    last_row  = (row9 + LenW'(1)) >= height_eff;
    run_start = pix_q && !in_set_run_q;
    do_adv    = run_start && (row_q > coded_row_q);
    cc1       = do_adv ? '0 : LenW'(coded_column_q);
    set_en    = (pix_q && last_col) || (!pix_q && in_set_run_q);
    set_to    = pix_q ? (col9 + LenW'(1)) : col9;
    img_end   = last_col && last_row;
  end

  // Clear gap before a new set run
  mbrle_chunker u_clr_chunker (
    .en_i     (run_start),
    .from_i   (cc1),
    .to_i     (col9),
    .chunks_o (clr_chunks),
    .pos_o    (cc2)
  );

  // Set run closing on a clear pixel or at line end
  mbrle_chunker u_set_chunker (
    .en_i     (set_en),
    .from_i   (cc2),
    .to_i     (set_to),
    .chunks_o (set_chunks),
    .pos_o    (cc3)
  );

  assign new_mask = {img_end, set_chunks.vld, clr_chunks.vld, do_adv};

  // Advance position
  always_comb begin
    column_d       = last_col ? '0 : (column_q + ColW'(1));
    row_d          = row_q;
    coded_column_d = CcW'(cc3);
    coded_row_d    = do_adv ? row_q : coded_row_q;
    in_set_run_d   = pix_q && !last_col;
    if (last_col) begin
      row_d = row_q + RowW'(1);
    end
    if (img_end) begin
      row_d          = '0;
      coded_column_d = '0;
      coded_row_d    = '0;
      in_set_run_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q       <= '0;
      row_q          <= '0;
      coded_column_q <= '0;
      coded_row_q    <= '0;
      in_set_run_q   <= 1'b0;
    end else if (cfg_wr) begin
      column_q       <= '0;
      row_q          <= '0;
      coded_column_q <= '0;
      coded_row_q    <= '0;
      in_set_run_q   <= 1'b0;
    end else if (fire) begin
      column_q       <= column_d;
      row_q          <= row_d;
      coded_column_q <= coded_column_d;
      coded_row_q    <= coded_row_d;
      in_set_run_q   <= in_set_run_d;
    end
  end

  // Code buffer: one slot per possible code of a pixel
  logic [NumSlots-1:0] mask_q, mask_d, mask_rest;
  logic [7:0]          adv_cnt_q;
  chunk_set_t          clr_q, set_q;
  logic                out_fire, buf_free, load;

  assign mask_rest = mask_q & (mask_q - NumSlots'(1));
  assign out_valid_o = (mask_q != '0);
  assign out_fire = out_valid_o && out_ready_i;
  assign buf_free = (mask_q == '0) || (out_ready_i && (mask_rest == '0));
  assign fire     = in_vld_q && ((new_mask == '0) || buf_free);
  assign load     = fire && (new_mask != '0);

  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = new_mask;
    end else if (out_fire) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      adv_cnt_q <= 8'(row_q - coded_row_q);
      clr_q     <= clr_chunks;
      set_q     <= set_chunks;
    end
  end

  // Offer the lowest pending slot
  logic [NumSlots-1:0][7:0] slot_code;
  logic [NumSlots-1:0][7:0] slot_cnt;

  always_comb begin
    slot_code = '0;
    slot_cnt  = '0;
    slot_code[SlotAdv] = CodeNextLine;
    slot_cnt[SlotAdv]  = adv_cnt_q;
    for (int k = 0; k < NumChunks; k++) begin
      slot_code[SlotClr0 + k] = {FlagClear, clr_q.len[k]};
      slot_cnt[SlotClr0 + k]  = 8'd1;
      slot_code[SlotSet0 + k] = {FlagSet, set_q.len[k]};
      slot_cnt[SlotSet0 + k]  = 8'd1;
    end
    slot_code[SlotEnd] = CodeEnd;
    slot_cnt[SlotEnd]  = 8'd1;
  end

  always_comb begin
    code_byte_o    = CodeEnd;
    repeat_count_o = 8'd1;
    for (int k = NumSlots - 1; k >= 0; k--) begin
      if (mask_q[k]) begin
        code_byte_o    = slot_code[k];
        repeat_count_o = slot_cnt[k];
      end
    end
  end

  assign last_of_run_o = (mask_rest == '0);

  // Checks
  a_coded_row_behind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coded_row_q <= row_q)
    else $error("coded row ran ahead of current row");

  a_stall_keeps_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (mask_q != '0))
    else $error("pending codes lost during receiver stall");

  a_line_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && last_col) |=> !in_set_run_q)
    else $error("set run left open across line end");

endmodule

@@ bench/mono_bitmap_run_length_encoder_tb.sv @@
module mono_bitmap_run_length_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrle_pkg::*;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned MaxCodes   = 6;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned CycleLimit = 400000;

  typedef enum int unsigned {
    RegImageWidth  = 0,
    RegImageHeight = 1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic [7:0] repeat_count;
    logic       last_of_run;
  } code_beat_t;

  // Raster encoder predictor plus queue of code beats still owed by the block
  class rle_scoreboard;
    logic [8:0]   width_reg;
    logic [8:0]   height_reg;
    logic [7:0]   column;
    logic [7:0]   row;
    logic [8:0]   coded_column;
    logic [7:0]   coded_row;
    bit           in_set_run;
    code_beat_t   pending_codes[$];
    code_beat_t   pixel_codes[$];
    int unsigned  errors;

    function new();
      width_reg  = 9'd256;
      height_reg = 9'd256;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      column       = '0;
      row          = '0;
      coded_column = '0;
      coded_row    = '0;
      in_set_run   = 1'b0;
    endfunction

    // Any register write drops the image in progress
    function void set_register(cfg_reg_e idx, logic [8:0] value);
      if (idx == RegImageWidth) width_reg = value;
      else height_reg = value;
      restart();
    endfunction

    function void push_code(logic [7:0] code, logic [7:0] count);
      if (pixel_codes.size() < MaxCodes)
        pixel_codes.push_back('{code_byte: code, repeat_count: count, last_of_run: 1'b0});
    endfunction

    // Split a span up to target into chunks of at most 127
    function void code_chunks(logic flag, int unsigned target);
      int unsigned len;
      while (coded_column < target) begin
        len = target - coded_column;
        if (len > ChunkMax) len = ChunkMax;
        push_code({flag, 7'(len)}, 8'd1);
        coded_column = coded_column + 9'(len);
      end
    endfunction

    function void note_pixel(logic pix);
      int unsigned w;
      int unsigned h;
      bit          last_col;
      bit          last_row;
      code_beat_t  beat;
      w = (width_reg == 0) ? 1 : (width_reg > MaxWidth) ? MaxWidth : int'(width_reg);
      h = (height_reg == 0) ? 1 : (height_reg > MaxHeight) ? MaxHeight : int'(height_reg);
      last_col = (int'(column) + 1 >= w);
      last_row = (int'(row) + 1 >= h);
      pixel_codes.delete();

      if (pix) begin
        if (!in_set_run) begin
          // flush owed line advances and the clear gap ahead of this set run
          if (row > coded_row) begin
            push_code(CodeNextLine, row - coded_row);
            coded_row    = row;
            coded_column = '0;
          end
          code_chunks(FlagClear, column);
          in_set_run = 1'b1;
        end
        if (last_col) begin
          code_chunks(FlagSet, int'(column) + 1);
          in_set_run = 1'b0;
        end
      end else if (in_set_run) begin
        code_chunks(FlagSet, column);
        in_set_run = 1'b0;
      end

      // advance the raster position
      if (last_col) begin
        column     = '0;
        in_set_run = 1'b0;
        if (last_row) begin
          push_code(CodeEnd, 8'd1);
          restart();
        end else begin
          row = row + 8'd1;
        end
      end else begin
        column = column + 8'd1;
      end

      if (pixel_codes.size() > 0) begin
        beat = pixel_codes.pop_back();
        beat.last_of_run = 1'b1;
        pixel_codes.push_back(beat);
      end
      foreach (pixel_codes[i]) pending_codes.push_back(pixel_codes[i]);
    endfunction

    function void check_code(logic [7:0] code, logic [7:0] count, logic last);
      code_beat_t exp_beat;
      if (pending_codes.size() == 0) begin
        $display("%0t: unexpected code beat, got code %02h count %0d last %0b",
                 $time, code, count, last);
        errors++;
        return;
      end
      exp_beat = pending_codes.pop_front();
      if (code !== exp_beat.code_byte) begin
        $display("%0t: code_byte expected %02h, got %02h", $time, exp_beat.code_byte, code);
        errors++;
      end
      if (count !== exp_beat.repeat_count) begin
        $display("%0t: repeat_count expected %0d, got %0d",
                 $time, exp_beat.repeat_count, count);
        errors++;
      end
      if (last !== exp_beat.last_of_run) begin
        $display("%0t: last_of_run expected %0b, got %0b",
                 $time, exp_beat.last_of_run, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_codes.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                pixel_set_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          code_byte_o;
  logic [7:0]          repeat_count_o;
  logic                last_of_run_o;

  rle_scoreboard sb;
  bit            idle_on = 1'b1;
  int unsigned   cycles  = 0;

  mono_bitmap_run_length_encoder #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_set_i   (pixel_set_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_byte_o   (code_byte_o),
    .repeat_count_o(repeat_count_o),
    .last_of_run_o (last_of_run_o)
  );

  always #4 clk_i = ~clk_i;

  // Stall the code channel now and then
  always @(negedge clk_i) begin
    out_ready_i = !(idle_on && $urandom_range(99) < 10);
  end

  // Check every accepted code beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_code(code_byte_o, repeat_count_o, last_of_run_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout with %0d code beats outstanding", $time, sb.pending());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_pixel(input logic pix);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 10) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    pixel_set_i = pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_pixel(pix);
  endtask

  // Drop valid and wait until every owed code beat has left
  task automatic hold_until_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [8:0] value);
    settle();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ApbAddrW'(4 * int'(idx));
    pwdata  = ApbDataW'(value);
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_register(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_size(input logic [8:0] w, input logic [8:0] h);
    write_reg(RegImageWidth, w);
    write_reg(RegImageHeight, h);
  endtask

  // Send n pixels, LSB first
  task automatic send_pattern(input logic [31:0] bits, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(bits[i]);
  endtask

  task automatic send_same(input logic pix, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_pixel(pix);
  endtask

  // Random runs of set and clear pixels, with an occasional full drain
  task automatic send_runs(input int unsigned count, input int unsigned max_run,
                           input int unsigned set_pct);
    int unsigned sent;
    int unsigned run_len;
    logic        pix;
    sent = 0;
    while (sent < count) begin
      pix     = ($urandom_range(99) < set_pct);
      run_len = $urandom_range(max_run, 1);
      if ($urandom_range(39) == 0) hold_until_drained();
      for (int unsigned i = 0; i < run_len && sent < count; i++) begin
        send_pixel(pix);
        sent++;
      end
    end
  endtask

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    pixel_set_i = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset size: short set runs and a clear gap
    send_pattern(32'h23, 7);

    // Zero sizes act as one pixel: every pixel ends an image
    set_size(9'd0, 9'd0);
    send_pattern(32'h5, 3);

    // Set run reaching line end, empty trailing line, deferred line advance
    set_size(9'd3, 9'd2);
    send_pattern(32'h446, 12);

    // No idling on either side: a long set run split in two, then random runs
    idle_on = 1'b0;
    set_size(9'd128, 9'd1);
    send_same(1'b1, 128);
    set_size(9'd8, 9'd4);
    send_runs(40, 10, 50);
    idle_on = 1'b1;

    // Deferred line advance with a repeat count, oversized height
    set_size(9'd1, 9'd300);
    send_same(1'b0, 30);
    send_pixel(1'b1);

    // Oversized width, clear gap split into three chunks before a set pixel at line end
    set_size(9'd511, 9'd1);
    send_same(1'b0, 255);
    send_pixel(1'b1);
    hold_until_drained();

    set_size(9'd17, 9'd511);
    send_runs(30, 20, 40);

    set_size(9'd5, 9'd0);
    send_runs(15, 6, 50);

    set_size(9'd3, 9'd7);
    send_runs(15, 30, 50);

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
